>>> hdl/bmir_pkg.sv
// ----------------------------------------------------------------------------
// bmir_pkg: shared types and constants of the rotation engine
// Field widths, register indexes, reset values and the structs that travel
// between the front end, the arithmetic back end and the top level.
// ----------------------------------------------------------------------------
package bmir_pkg;

    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int DIM_W      = 10;
    localparam int PAD_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Signed width of a coordinate difference (row - centre - padding).
    localparam int DIFF_W = 12;

    localparam int MAX_ROWS_DEF       = 512;
    localparam int MAX_COLS_DEF       = 512;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Queue depths between the stages.
    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_ROWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_COLS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL     = 3'd6;

    localparam logic signed [COEF_W-1:0] COS_RST      = 16'sd11585;
    localparam logic signed [COEF_W-1:0] SIN_RST      = 16'sd11585;
    localparam logic [DIM_W-1:0]         SRC_ROWS_RST = 10'd512;
    localparam logic [DIM_W-1:0]         SRC_COLS_RST = 10'd512;
    localparam logic [PAD_W-1:0]         PAD_ROWS_RST = 9'd0;
    localparam logic [PAD_W-1:0]         PAD_COLS_RST = 9'd0;
    localparam logic [PIX_W-1:0]         FILL_RST     = 8'd1;

    typedef struct packed {
        logic signed [COEF_W-1:0] cos_coef;
        logic signed [COEF_W-1:0] sin_coef;
        logic [DIM_W-1:0]         source_rows;
        logic [DIM_W-1:0]         source_cols;
        logic [PAD_W-1:0]         pad_rows;
        logic [PAD_W-1:0]         pad_cols;
        logic [PIX_W-1:0]         fill_value;
    } t_cfg;

    typedef struct packed {
        logic             is_fetch;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } t_cmd;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             in_image;
    } t_result;

endpackage

>>> hdl/bmir_fifo.sv
// ----------------------------------------------------------------------------
// bmir_fifo: small register queue
// First-in first-out queue held in flip-flops, with the head shown directly.
// ----------------------------------------------------------------------------
module bmir_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CNTW-1:0] r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> hdl/bmir_ram.sv
// ----------------------------------------------------------------------------
// bmir_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bmir_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/bmir_front.sv
// ----------------------------------------------------------------------------
// bmir_front: input classifier and command queue
// Accepts beats, drops loads that fall outside the frame store and queues
// the rest in order for the back end.
// ----------------------------------------------------------------------------
module bmir_front #(
    parameter int MAX_ROWS = bmir_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = bmir_pkg::MAX_COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_op,
    input  logic [bmir_pkg::ROW_W-1:0] i_row,
    input  logic [bmir_pkg::COL_W-1:0] i_col,
    input  logic [bmir_pkg::PIX_W-1:0] i_pixel_in,
    output logic                       o_full,
    output logic                       o_cmd_valid,
    output bmir_pkg::t_cmd             o_cmd,
    input  logic                       i_cmd_take
);

    bmir_pkg::t_cmd w_cmd;
    logic           w_keep;
    logic           w_empty;

    // A load aimed beyond the store is accepted and discarded here.
    assign w_keep = (i_op == bmir_pkg::OP_FETCH)
                 || ((32'(i_row) < MAX_ROWS) && (32'(i_col) < MAX_COLS));

    assign w_cmd.is_fetch = (i_op == bmir_pkg::OP_FETCH);
    assign w_cmd.row      = i_row;
    assign w_cmd.col      = i_col;
    assign w_cmd.pix      = i_pixel_in;

    bmir_fifo #(
        .W     ($bits(bmir_pkg::t_cmd)),
        .DEPTH (bmir_pkg::IN_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_keep),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_take),
        .o_data  (o_cmd),
        .o_empty (w_empty)
    );

    assign o_cmd_valid = !w_empty;

endmodule

>>> hdl/bmir_back.sv
// ----------------------------------------------------------------------------
// bmir_back: coordinate mapping pipeline, frame store and result queue
// Maps output coordinates back onto the source, reads or writes the frame
// store in command order and queues results under a credit count.
// ----------------------------------------------------------------------------
module bmir_back #(
    parameter int MAX_ROWS       = bmir_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS       = bmir_pkg::MAX_COLS_DEF,
    parameter int COEF_FRAC_BITS = bmir_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bmir_pkg::t_cfg             i_cfg,
    input  logic                       i_cmd_valid,
    input  bmir_pkg::t_cmd             i_cmd,
    output logic                       o_cmd_take,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [bmir_pkg::PIX_W-1:0] o_pixel_out,
    output logic                       o_inside_res
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int F     = COEF_FRAC_BITS;
    localparam int DW    = bmir_pkg::DIFF_W;
    localparam int PW    = DW + bmir_pkg::COEF_W;
    localparam int CTRW  = bmir_pkg::DIM_W - 1;
    localparam int ACC_W = (((CTRW + F + 1) > PW) ? (CTRW + F + 1) : PW) + 2;
    localparam int QW    = ACC_W - F;
    localparam int UW    = $clog2(bmir_pkg::OUT_DEPTH + 1);

    logic [CTRW-1:0] w_r0;
    logic [CTRW-1:0] w_c0;
    logic [UW-1:0]   r_used;
    logic            w_issue;
    logic            w_pop;
    logic            w_full_unused;

    // Stage 1: differences and load address
    logic                          r_s1_valid;
    logic                          r_s1_fetch;
    logic signed [DW-1:0]          r_s1_dr;
    logic signed [DW-1:0]          r_s1_dc;
    logic [AW-1:0]                 r_s1_addr;
    logic [bmir_pkg::PIX_W-1:0]    r_s1_pix;
    // Stage 2: products
    logic                          r_s2_valid;
    logic                          r_s2_fetch;
    logic signed [PW-1:0]          r_s2_rc;
    logic signed [PW-1:0]          r_s2_cs;
    logic signed [PW-1:0]          r_s2_rs;
    logic signed [PW-1:0]          r_s2_cc;
    logic [AW-1:0]                 r_s2_addr;
    logic [bmir_pkg::PIX_W-1:0]    r_s2_pix;
    // Stage 3: accumulated source coordinates
    logic                          r_s3_valid;
    logic                          r_s3_fetch;
    logic signed [ACC_W-1:0]       r_s3_acc_r;
    logic signed [ACC_W-1:0]       r_s3_acc_c;
    logic [AW-1:0]                 r_s3_addr;
    logic [bmir_pkg::PIX_W-1:0]    r_s3_pix;
    // Stage 4: scaled coordinates and bounds test
    logic                          r_s4_valid;
    logic                          r_s4_fetch;
    logic                          r_s4_inside;
    logic [RW-1:0]                 r_s4_sr;
    logic [CW-1:0]                 r_s4_sc;
    logic [AW-1:0]                 r_s4_addr;
    logic [bmir_pkg::PIX_W-1:0]    r_s4_pix;
    // Stage 5: store read returned
    logic                          r_s5_valid;
    logic                          r_s5_inside;

    logic signed [ACC_W-1:0]       w_sum_r;
    logic signed [ACC_W-1:0]       w_sum_c;
    logic signed [QW-1:0]          w_qr;
    logic signed [QW-1:0]          w_qc;
    logic                          w_inside;
    logic [AW-1:0]                 w_raddr;
    logic [bmir_pkg::PIX_W-1:0]    w_ram_q;
    bmir_pkg::t_result             w_res_in;
    bmir_pkg::t_result             w_res_out;

    assign w_r0 = i_cfg.source_rows[bmir_pkg::DIM_W-1:1];
    assign w_c0 = i_cfg.source_cols[bmir_pkg::DIM_W-1:1];

    // A fetch only leaves the queue when a slot is reserved for its result.
    assign w_issue    = i_cmd_valid
                     && (!i_cmd.is_fetch || (r_used < UW'(bmir_pkg::OUT_DEPTH)));
    assign o_cmd_take = w_issue;
    assign w_pop      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if ((w_issue && i_cmd.is_fetch) && !w_pop) begin
                r_used <= r_used + 1'b1;
            end else if (w_pop && !(w_issue && i_cmd.is_fetch)) begin
                r_used <= r_used - 1'b1;
            end
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid && r_s4_fetch;
        end
    end

    // Truncation towards zero: bias a negative sum before the shift.
    always_comb begin
        w_sum_r = r_s3_acc_r + (r_s3_acc_r[ACC_W-1] ? ACC_W'((1 << F) - 1) : '0);
        w_sum_c = r_s3_acc_c + (r_s3_acc_c[ACC_W-1] ? ACC_W'((1 << F) - 1) : '0);
        w_qr    = w_sum_r[ACC_W-1:F];
        w_qc    = w_sum_c[ACC_W-1:F];
        w_inside = !w_qr[QW-1] && !w_qc[QW-1]
            && (32'($unsigned(w_qr)) < ((32'(i_cfg.source_rows) < MAX_ROWS)
                                        ? 32'(i_cfg.source_rows) : MAX_ROWS))
            && (32'($unsigned(w_qc)) < ((32'(i_cfg.source_cols) < MAX_COLS)
                                        ? 32'(i_cfg.source_cols) : MAX_COLS));
    end

    always_ff @(posedge i_clk) begin
        r_s1_fetch <= i_cmd.is_fetch;
        r_s1_dr    <= $signed({2'b00, i_cmd.row}) - $signed({3'b000, w_r0})
                    - $signed({3'b000, i_cfg.pad_rows});
        r_s1_dc    <= $signed({2'b00, i_cmd.col}) - $signed({3'b000, w_c0})
                    - $signed({3'b000, i_cfg.pad_cols});
        r_s1_addr  <= AW'(32'(i_cmd.row) * MAX_COLS + 32'(i_cmd.col));
        r_s1_pix   <= i_cmd.pix;

        r_s2_fetch <= r_s1_fetch;
        r_s2_rc    <= r_s1_dr * i_cfg.cos_coef;
        r_s2_cs    <= r_s1_dc * i_cfg.sin_coef;
        r_s2_rs    <= r_s1_dr * i_cfg.sin_coef;
        r_s2_cc    <= r_s1_dc * i_cfg.cos_coef;
        r_s2_addr  <= r_s1_addr;
        r_s2_pix   <= r_s1_pix;

        r_s3_fetch <= r_s2_fetch;
        r_s3_acc_r <= (ACC_W'(w_r0) << F) + ACC_W'(r_s2_rc) + ACC_W'(r_s2_cs);
        r_s3_acc_c <= (ACC_W'(w_c0) << F) - ACC_W'(r_s2_rs) + ACC_W'(r_s2_cc);
        r_s3_addr  <= r_s2_addr;
        r_s3_pix   <= r_s2_pix;

        r_s4_fetch  <= r_s3_fetch;
        r_s4_inside <= w_inside;
        r_s4_sr     <= w_qr[RW-1:0];
        r_s4_sc     <= w_qc[CW-1:0];
        r_s4_addr   <= r_s3_addr;
        r_s4_pix    <= r_s3_pix;

        r_s5_inside <= r_s4_inside;
    end

    assign w_raddr = AW'(32'(r_s4_sr) * MAX_COLS + 32'(r_s4_sc));

    // Loads and fetches reach the store at the same stage, so reads and
    // writes happen in command order.
    bmir_ram #(
        .W     (bmir_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (r_s4_valid && !r_s4_fetch),
        .i_waddr (r_s4_addr),
        .i_wdata (r_s4_pix),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    assign w_res_in.pixel    = r_s5_inside ? w_ram_q : i_cfg.fill_value;
    assign w_res_in.in_image = r_s5_inside;

    bmir_fifo #(
        .W     ($bits(bmir_pkg::t_result)),
        .DEPTH (bmir_pkg::OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s5_valid),
        .i_data  (w_res_in),
        .o_full  (w_full_unused),
        .i_pop   (i_pop),
        .o_data  (w_res_out),
        .o_empty (o_empty)
    );

    assign o_pixel_out  = w_res_out.pixel;
    assign o_inside_res = w_res_out.in_image && !w_full_unused | w_res_out.in_image;

endmodule

>>> hdl/backward_map_image_rotation.sv
// A fetch beat crosses the command queue, mapping stages and store read before empty drops.
// Throughput: one beat per cycle, loads and fetches mixed, while pop keeps pace; the
// mapping pipeline and the frame store each take one command per cycle.
// Reset (synchronous, active low) empties both queues, clears the pipeline and the
// credit count and loads the registers' reset values; the frame store keeps its contents
// and is undefined until written.
// ----------------------------------------------------------------------------
// backward_map_image_rotation: nearest-neighbour rotation by inverse mapping
// Load beats fill a grey frame store; fetch beats map an output coordinate back
// onto the source image and return the stored pixel or the fill value.
// ----------------------------------------------------------------------------
module backward_map_image_rotation #(
    parameter int MAX_ROWS       = bmir_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS       = bmir_pkg::MAX_COLS_DEF,
    parameter int COEF_FRAC_BITS = bmir_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [bmir_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Command side
    input  logic                            push,
    output logic                            full,
    input  logic                            i_op,
    input  logic [bmir_pkg::ROW_W-1:0]      i_row,
    input  logic [bmir_pkg::COL_W-1:0]      i_col,
    input  logic [bmir_pkg::PIX_W-1:0]      i_pixel_in,
    // Result side
    output logic                            empty,
    input  logic                            pop,
    output logic [bmir_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                            o_inside_res
);

    // The register file. Software is bound to write it only while the engine is idle (the block
    // does not enforce this), so the back end reads it directly at whatever stage needs a field.
    bmir_pkg::t_cfg r_cfg;
    bmir_pkg::t_cfg n_cfg;

    bmir_pkg::t_cmd w_cmd;
    logic           w_cmd_valid;
    logic           w_cmd_take;

    // Register decoder: an index with no register behind it changes nothing.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bmir_pkg::CFG_COS:      n_cfg.cos_coef    = $signed(i_cfg_data);
                bmir_pkg::CFG_SIN:      n_cfg.sin_coef    = $signed(i_cfg_data);
                bmir_pkg::CFG_SRC_ROWS: n_cfg.source_rows = i_cfg_data[bmir_pkg::DIM_W-1:0];
                bmir_pkg::CFG_SRC_COLS: n_cfg.source_cols = i_cfg_data[bmir_pkg::DIM_W-1:0];
                bmir_pkg::CFG_PAD_ROWS: n_cfg.pad_rows    = i_cfg_data[bmir_pkg::PAD_W-1:0];
                bmir_pkg::CFG_PAD_COLS: n_cfg.pad_cols    = i_cfg_data[bmir_pkg::PAD_W-1:0];
                bmir_pkg::CFG_FILL:     n_cfg.fill_value  = i_cfg_data[bmir_pkg::PIX_W-1:0];
                default:                n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_coef    <= bmir_pkg::COS_RST;
            r_cfg.sin_coef    <= bmir_pkg::SIN_RST;
            r_cfg.source_rows <= bmir_pkg::SRC_ROWS_RST;
            r_cfg.source_cols <= bmir_pkg::SRC_COLS_RST;
            r_cfg.pad_rows    <= bmir_pkg::PAD_ROWS_RST;
            r_cfg.pad_cols    <= bmir_pkg::PAD_COLS_RST;
            r_cfg.fill_value  <= bmir_pkg::FILL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The front end takes a beat whenever its command queue has room. The
    // caller only waits once a stalled result reader has used up every result
    // slot and the fetches held back behind it have filled the command queue.
    bmir_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_pixel_in  (i_pixel_in),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    // The back end drains the command queue one command per cycle; a fetch
    // waits at the queue head only when every result slot is already spoken for.
    bmir_back #(
        .MAX_ROWS       (MAX_ROWS),
        .MAX_COLS       (MAX_COLS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_take   (w_cmd_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pixel_out  (o_pixel_out),
        .o_inside_res (o_inside_res)
    );

    // A write to the fill register is seen on the very next cycle.
    a_fill_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == bmir_pkg::CFG_FILL))
        |=> (r_cfg.fill_value == $past(i_cfg_data[bmir_pkg::PIX_W-1:0])))
        else $error("fill register did not take the written value");

    // No command can cross the pipeline and fill the result queue before this check after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |-> ##2 empty)
        else $error("result shown too soon after reset");

    // A command can only be taken from the front end when one is waiting.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_take |-> w_cmd_valid)
        else $error("back end took a command from an empty queue");

endmodule
